/* hdl/rmcs_pkg.sv */
// Shared constants, action codes and the controller-to-datapath command word
// for the RGB matrix column shifter. No dependencies.
`default_nettype none

package rmcs_pkg;

    localparam int COLUMNS     = 8;
    localparam int ROWS        = 8;
    localparam int GAIN_GROUPS = 24;

    localparam int COL_W   = 3;   // column field width
    localparam int ROW_W   = 3;   // row field width
    localparam int IDX_W   = 5;   // word_index width
    localparam int GAIN_W  = 6;   // brightness width
    localparam int PIX_W   = 24;  // red:green:blue
    localparam int WORD_W  = 48;
    localparam int EN_W    = 8;
    localparam int DEPTH   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam logic [1:0] ACT_WRITE   = 2'd0;
    localparam logic [1:0] ACT_GAIN    = 2'd1;
    localparam logic [1:0] ACT_REFRESH = 2'd2;

    // Command word from controller to datapath, valid for one cycle.
    typedef struct packed {
        logic             capture;  // latch column of accepted word
        logic             wr;       // store pixel this cycle
        logic             issue;    // read / emit one output word
        logic             gain;     // word goes to brightness bank
        logic [IDX_W-1:0] idx;      // row or group number
        logic             fin;      // final word of the action
    } cmd_t;

    function automatic logic [ADDR_W-1:0] pix_addr(input logic [IDX_W-1:0] r,
                                                   input logic [COL_W-1:0] c);
        return ADDR_W'(32'(r) * COLUMNS + 32'(c));
    endfunction

endpackage

`default_nettype wire

/* hdl/rmcs_ctrl.sv */
// Controller FSM: decodes accepted actions and sequences output words.
// Depends on rmcs_pkg.
`default_nettype none

module rmcs_ctrl
    import rmcs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       action,
    input  wire logic [COL_W-1:0] column,
    input  wire logic [ROW_W-1:0] row,
    output logic                  busy,
    output cmd_t                  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PIXEL,
        ST_GAIN
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             accept;
    logic             col_ok, row_ok;
    logic             pix_fin, gain_fin;

    assign accept   = start && !busy_reg;
    assign col_ok   = 32'(column) < COLUMNS;
    assign row_ok   = 32'(row) < ROWS;
    assign pix_fin  = 32'(cnt_reg) == ROWS - 1;
    assign gain_fin = 32'(cnt_reg) == GAIN_GROUPS - 1;
    assign busy     = busy_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd.capture = 1'b0;
        cmd.wr      = 1'b0;
        cmd.issue   = 1'b0;
        cmd.gain    = 1'b0;
        cmd.idx     = cnt_reg;
        cmd.fin     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    unique case (action)
                        ACT_WRITE:
                        begin
                            if (col_ok && row_ok)
                            begin
                                cmd.wr     = 1'b1;
                                state_next = ST_PIXEL;
                            end
                        end
                        ACT_REFRESH:
                        begin
                            if (col_ok)
                                state_next = ST_PIXEL;
                        end
                        ACT_GAIN:
                            state_next = ST_GAIN;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PIXEL:
            begin
                cmd.issue = 1'b1;
                cmd.fin   = pix_fin;
                cnt_next  = cnt_reg + 1'b1;
                if (pix_fin)
                    state_next = ST_IDLE;
            end
            ST_GAIN:
            begin
                cmd.issue = 1'b1;
                cmd.gain  = 1'b1;
                cmd.fin   = gain_fin;
                cnt_next  = cnt_reg + 1'b1;
                if (gain_fin)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
        busy_next = state_next != ST_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/rmcs_datapath.sv */
// Datapath: pixel memory with valid bits, brightness register and the
// two-stage read / output pipeline. Depends on rmcs_pkg.
`default_nettype none

module rmcs_datapath
    import rmcs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmd_t              cmd,
    input  wire logic [COL_W-1:0]  column,
    input  wire logic [ROW_W-1:0]  row,
    input  wire logic [7:0]        red,
    input  wire logic [7:0]        green,
    input  wire logic [7:0]        blue,
    input  wire logic              brightness_we,
    input  wire logic [GAIN_W-1:0] brightness_wdata,
    output logic                   word_valid,
    output logic [WORD_W-1:0]      shift_word,
    output logic                   to_brightness_bank,
    output logic [IDX_W-1:0]       word_index,
    output logic [EN_W-1:0]        column_enable,
    output logic                   last
);

    logic [PIX_W-1:0]  mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [COL_W-1:0]  col_reg;

    logic [ADDR_W-1:0] wr_addr, rd_addr;

    // stage 1: read issued
    logic              s1_valid_reg;
    logic              s1_gain_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s1_fin_reg;
    logic [PIX_W-1:0]  s1_data_reg;
    logic              s1_hit_reg;

    // stage 2: output registers
    logic              out_valid_reg;
    logic [WORD_W-1:0] out_word_reg;
    logic              out_bank_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic [EN_W-1:0]   out_en_reg;
    logic              out_last_reg;

    assign wr_addr = pix_addr(IDX_W'(row), column);
    assign rd_addr = pix_addr(cmd.idx, col_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.wr)
            mem[wr_addr] <= {red, green, blue};
        s1_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            gain_reg <= '1;
        end
        else
        begin
            if (cmd.wr)
                vld_reg[wr_addr] <= 1'b1;
            if (brightness_we)
                gain_reg <= brightness_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            col_reg <= column;
        s1_gain_reg <= cmd.gain;
        s1_idx_reg  <= cmd.idx;
        s1_fin_reg  <= cmd.fin;
        s1_hit_reg  <= vld_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= cmd.issue;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_gain_reg)
            out_word_reg <= {8{gain_reg}};
        else if (s1_hit_reg)
            out_word_reg <= WORD_W'(s1_data_reg);
        else
            out_word_reg <= '0;
        out_bank_reg <= s1_gain_reg;
        out_idx_reg  <= s1_idx_reg;
        out_last_reg <= s1_fin_reg;
        // column strobe only on the latch word of a write or refresh
        out_en_reg   <= (s1_fin_reg && !s1_gain_reg) ? (EN_W'(1) << col_reg) : '0;
    end

    assign word_valid         = out_valid_reg;
    assign shift_word         = out_word_reg;
    assign to_brightness_bank = out_bank_reg;
    assign word_index         = out_idx_reg;
    assign column_enable      = out_en_reg;
    assign last               = out_last_reg;

endmodule

`default_nettype wire

/* hdl/rgb_matrix_column_shifter.sv */
// Top level of the RGB matrix column shifter: controller plus datapath.
// Depends on rmcs_pkg, rmcs_ctrl, rmcs_datapath.
//
//  channel   handshake                  payload
//  -------   -------------------------  ---------------------------------------
//  command   start / busy               action, column, row, red, green, blue
//  result    word_valid (1-cycle pulse) shift_word, to_brightness_bank,
//                                       word_index, column_enable, last
//  config    brightness_we              brightness_wdata
//
// A command word is taken when start is high and busy is low. busy then stays
// high while ROWS words (write or refresh) or GAIN_GROUPS words (brightness
// load) are issued, one memory read per cycle. Each output word is registered
// in the stage-1 and output registers after its read; an ignored word never
// raises busy. Reset clears the pixel valid bits (store reads as zero) and sets
// brightness to all ones. The receiver cannot stall: words are one-cycle pulses.
`default_nettype none

module rgb_matrix_column_shifter
    import rmcs_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        action,
    input  wire logic [COL_W-1:0]  column,
    input  wire logic [ROW_W-1:0]  row,
    input  wire logic [7:0]        red,
    input  wire logic [7:0]        green,
    input  wire logic [7:0]        blue,
    input  wire logic              brightness_we,
    input  wire logic [GAIN_W-1:0] brightness_wdata,
    output logic                   word_valid,
    output logic [WORD_W-1:0]      shift_word,
    output logic                   to_brightness_bank,
    output logic [IDX_W-1:0]       word_index,
    output logic [EN_W-1:0]        column_enable,
    output logic                   last
);

    cmd_t cmd;

    // sequencing: accept, decode, range checks, word counter
    rmcs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .column (column),
        .row    (row),
        .busy   (busy),
        .cmd    (cmd)
    );

    // storage and output pipeline
    rmcs_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .column             (column),
        .row                (row),
        .red                (red),
        .green              (green),
        .blue               (blue),
        .brightness_we      (brightness_we),
        .brightness_wdata   (brightness_wdata),
        .word_valid         (word_valid),
        .shift_word         (shift_word),
        .to_brightness_bank (to_brightness_bank),
        .word_index         (word_index),
        .column_enable      (column_enable),
        .last               (last)
    );

endmodule

`default_nettype wire
